FILE: hw/rtl/nip_pkg.sv
// shared types and constants of the nec infrared pulse decoder
// no dependencies; imported by nip_window and nec_ir_pulse_decoder
`default_nettype none

package nip_pkg;

  localparam int unsigned PeriodW = 16;
  localparam int unsigned TolW    = 6;
  localparam int unsigned CountW  = 6;
  localparam int unsigned KeyW    = 8;
  localparam int unsigned FrameW  = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned ProdW   = PeriodW + TolW;

  // x / 100 for x below 2**22 as (x * RecipMul) >> RecipShift
  localparam int unsigned RecipShift = 29;
  localparam int unsigned RecipW     = 23;
  localparam logic [RecipW-1:0] RecipMul = 23'd5368710;

  localparam logic [KeyW-1:0]    NoKey        = 8'hFF;
  localparam logic [CountW-1:0]  FullCount    = 6'd32;
  localparam logic [CountW-1:0]  OverCount    = 6'd33;
  localparam logic [TolW-1:0]    TolReset     = 6'd5;
  localparam logic [PeriodW-1:0] StartReset   = 16'd13500;
  localparam logic [PeriodW-1:0] EndReset     = 16'd40450;
  localparam logic [PeriodW-1:0] OneReset     = 16'd2245;
  localparam logic [PeriodW-1:0] ZeroReset    = 16'd1135;
  localparam logic [1:0]         SettleCycles = 2'd3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTolerance = 3'd0,
    CfgStart     = 3'd1,
    CfgEnd       = 3'd2,
    CfgOne       = 3'd3,
    CfgZero      = 3'd4
  } cfg_idx_e;

  // open window: lo < period < hi
  typedef struct packed {
    logic [PeriodW-1:0] lo;
    logic [PeriodW:0]   hi;
  } win_t;

endpackage

`default_nettype wire

FILE: hw/rtl/nip_window.sv
// window bound unit: nominal +/- (nominal * tolerance / 100), three register stages
// depends on nip_pkg
`default_nettype none

module nip_window (
  input  wire logic                        clk_i,
  input  wire logic [nip_pkg::PeriodW-1:0] nominal_i,
  input  wire logic [nip_pkg::TolW-1:0]    tol_i,
  output nip_pkg::win_t                    bounds_o
);
  import nip_pkg::*;

  logic [ProdW-1:0]          prod_d, prod_q;
  logic [PeriodW-1:0]        nom1_q, nom2_q;
  logic [ProdW+RecipW-1:0]   scaled;
  logic [PeriodW-1:0]        dev_d, dev_q;
  win_t                      bounds_d, bounds_q;

  assign prod_d = ProdW'(nominal_i) * ProdW'(tol_i);
  // divide by 100 through the reciprocal; deviation never exceeds nominal
  assign scaled = (ProdW+RecipW)'(prod_q) * (ProdW+RecipW)'(RecipMul);
  assign dev_d  = scaled[RecipShift +: PeriodW];

  always_comb begin
    bounds_d.lo = nom2_q - dev_q;
    bounds_d.hi = {1'b0, nom2_q} + {1'b0, dev_q};
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    nom1_q   <= nominal_i;
    dev_q    <= dev_d;
    nom2_q   <= nom1_q;
    bounds_q <= bounds_d;
  end

  assign bounds_o = bounds_q;

endmodule

`default_nettype wire

FILE: hw/rtl/nec_ir_pulse_decoder.sv
// nec infrared decoder top level: config registers, frame state, result register
// depends on nip_pkg and nip_window
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-------------------------------
//   in      | input     | in_valid_i / in_stall_o   | command_i, period_i
//   out     | output    | out_valid_o / out_stall_i | key_code_o, frame_done_o, bits_seen_o
//   cfg     | input     | cfg_we_i                  | cfg_index_i, cfg_data_i
//
// one word per cycle while the input is not stalled; a word is decoded in its accept
// cycle and its result is registered, so the result appears in the cycle after.
// window bounds come from a three-stage multiply pipeline per window: after reset
// and after every config write the input stalls while they settle.
// the input stalls while the result register holds a word the far side stalls.
`default_nettype none

module nec_ir_pulse_decoder (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [nip_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [nip_pkg::PeriodW-1:0] cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        command_i,
  input  wire logic [nip_pkg::PeriodW-1:0] period_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [nip_pkg::KeyW-1:0]         key_code_o,
  output logic                             frame_done_o,
  output logic [nip_pkg::CountW-1:0]       bits_seen_o
);
  import nip_pkg::*;

  logic [TolW-1:0]    tol_q;
  logic [PeriodW-1:0] start_q, end_q, one_q, zero_q;
  logic [1:0]         settle_q;

  logic [FrameW-1:0]  frame_q, frame_d;
  logic [CountW-1:0]  count_q, count_d;
  logic [KeyW-1:0]    key_q, key_d;
  logic               done_d;

  logic               out_valid_q;
  logic [KeyW-1:0]    out_key_q;
  logic               out_done_q;
  logic [CountW-1:0]  out_count_q;

  win_t win_start, win_end, win_one, win_zero;
  logic hit_start, hit_end, hit_one, hit_zero;
  logic in_acc, out_acc;

  nip_window u_win_start (.clk_i, .nominal_i(start_q), .tol_i(tol_q), .bounds_o(win_start));
  nip_window u_win_end   (.clk_i, .nominal_i(end_q),   .tol_i(tol_q), .bounds_o(win_end));
  nip_window u_win_one   (.clk_i, .nominal_i(one_q),   .tol_i(tol_q), .bounds_o(win_one));
  nip_window u_win_zero  (.clk_i, .nominal_i(zero_q),  .tol_i(tol_q), .bounds_o(win_zero));

  assign hit_start = (period_i > win_start.lo) && ({1'b0, period_i} < win_start.hi);
  assign hit_end   = (period_i > win_end.lo)   && ({1'b0, period_i} < win_end.hi);
  assign hit_one   = (period_i > win_one.lo)   && ({1'b0, period_i} < win_one.hi);
  assign hit_zero  = (period_i > win_zero.lo)  && ({1'b0, period_i} < win_zero.hi);

  assign out_acc    = out_valid_q && !out_stall_i;
  assign in_stall_o = (settle_q != 2'd0) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    frame_d = frame_q;
    count_d = count_q;
    key_d   = key_q;
    done_d  = 1'b0;
    priority if (command_i) begin
      key_d = NoKey;
    end else if (hit_start) begin
      frame_d = '0;
      count_d = '0;
    end else if (hit_one) begin
      if (count_q < FullCount) begin
        frame_d[count_q[4:0]] = 1'b1;
      end
      if (count_q < OverCount) begin
        count_d = count_q + 1'b1;
      end
    end else if (hit_zero) begin
      if (count_q < OverCount) begin
        count_d = count_q + 1'b1;
      end
    end else if (hit_end) begin
      key_d   = (count_q == FullCount) ? frame_q[23:16] : NoKey;
      frame_d = '0;
      count_d = '0;
      done_d  = 1'b1;
    end else begin
      // unmatched period leaves everything as it is
      done_d = 1'b0;
    end
  end

  // configuration registers and settle counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q    <= TolReset;
      start_q  <= StartReset;
      end_q    <= EndReset;
      one_q    <= OneReset;
      zero_q   <= ZeroReset;
      settle_q <= SettleCycles;
    end else begin
      if (cfg_we_i) begin
        settle_q <= SettleCycles;
        unique case (cfg_index_i)
          CfgTolerance: tol_q   <= cfg_data_i[TolW-1:0];
          CfgStart:     start_q <= cfg_data_i;
          CfgEnd:       end_q   <= cfg_data_i;
          CfgOne:       one_q   <= cfg_data_i;
          CfgZero:      zero_q  <= cfg_data_i;
          default:      tol_q   <= tol_q;
        endcase
      end else if (settle_q != 2'd0) begin
        settle_q <= settle_q - 2'd1;
      end
    end
  end

  // frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
      count_q <= '0;
      key_q   <= NoKey;
    end else if (in_acc) begin
      frame_q <= frame_d;
      count_q <= count_d;
      key_q   <= key_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_acc) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_key_q   <= key_q;
      out_done_q  <= done_d;
      out_count_q <= count_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign key_code_o   = out_key_q;
  assign frame_done_o = out_done_q;
  assign bits_seen_o  = out_count_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (bits_seen_o <= OverCount))
    else $error("bit count beyond overflow value");

  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_done_o) |-> (bits_seen_o == '0))
    else $error("end of frame left a nonzero bit count");

  a_cfg_settle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> in_stall_o)
    else $error("word taken while window bounds settle");

  a_read_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && command_i) |=> (key_q == NoKey))
    else $error("read word did not clear the key");

endmodule

`default_nettype wire

FILE: tb/sv/nec_ir_pulse_decoder_tb.sv
// self-checking testbench of the nec infrared pulse decoder: directed window cases,
// then random well-formed, broken and noisy frames under several register settings
// depends on nip_pkg and the nec_ir_pulse_decoder rtl
`default_nettype none

module nec_ir_pulse_decoder_tb;
  import nip_pkg::*;

  localparam int unsigned CycleLimit = 800000;

  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic              done;
    logic [CountW-1:0] bits;
  } decode_word_t;

  typedef enum logic [1:0] {
    PulseStart,
    PulseOne,
    PulseZero,
    PulseEnd
  } pulse_e;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [PeriodW-1:0]  cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                command_i;
  logic [PeriodW-1:0]  period_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [KeyW-1:0]     key_code_o;
  logic                frame_done_o;
  logic [CountW-1:0]   bits_seen_o;

  // decoder shadow: registers and frame state
  logic [TolW-1:0]     tol_pct;
  logic [PeriodW-1:0]  nom_start;
  logic [PeriodW-1:0]  nom_end;
  logic [PeriodW-1:0]  nom_one;
  logic [PeriodW-1:0]  nom_zero;
  logic [FrameW-1:0]   frame_acc;
  logic [CountW-1:0]   bit_cnt;
  logic [KeyW-1:0]     key_held;

  decode_word_t        decoder_outputs_q[$];

  int unsigned         mismatches;
  int unsigned         words_sent;
  int unsigned         frames_ended;
  int unsigned         keys_decoded;
  int unsigned         settings_loaded;
  int unsigned         hold_req;
  int unsigned         cycle_count;
  bit                  burst_mode;

  nec_ir_pulse_decoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .period_i     (period_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .key_code_o   (key_code_o),
    .frame_done_o (frame_done_o),
    .bits_seen_o  (bits_seen_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned run_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(0, 3);
    if (r < 80) return $urandom_range(5, 20);
    return $urandom_range(40, 150);
  endfunction

  // open window: nominal - d < period < nominal + d, d truncated percent of nominal
  function automatic void window_bounds(input logic [PeriodW-1:0] nominal,
                                        output logic [PeriodW-1:0] lo,
                                        output logic [PeriodW:0] hi);
    logic [ProdW-1:0]   prod;
    logic [PeriodW-1:0] dev;
    prod = nominal * tol_pct;
    dev  = PeriodW'(prod / 100);
    lo   = nominal - dev;
    hi   = {1'b0, nominal} + dev;
  endfunction

  function automatic logic in_window(input logic [PeriodW-1:0] nominal,
                                     input logic [PeriodW-1:0] per);
    logic [PeriodW-1:0] lo;
    logic [PeriodW:0]   hi;
    window_bounds(nominal, lo, hi);
    return (per > lo) && ({1'b0, per} < hi);
  endfunction

  function automatic void predict_decode(input logic cmd, input logic [PeriodW-1:0] per);
    decode_word_t w;
    w.key  = key_held;
    w.done = 1'b0;
    if (cmd) begin
      key_held = NoKey;
    end else if (in_window(nom_start, per)) begin
      frame_acc = '0;
      bit_cnt   = '0;
    end else if (in_window(nom_one, per)) begin
      if (bit_cnt < FullCount) frame_acc[bit_cnt[4:0]] = 1'b1;
      if (bit_cnt < OverCount) bit_cnt = bit_cnt + 1'b1;
    end else if (in_window(nom_zero, per)) begin
      if (bit_cnt < OverCount) bit_cnt = bit_cnt + 1'b1;
    end else if (in_window(nom_end, per)) begin
      if (bit_cnt == FullCount) begin
        key_held = frame_acc[23:16];
        keys_decoded++;
      end else begin
        key_held = NoKey;
      end
      frame_acc = '0;
      bit_cnt   = '0;
      w.done    = 1'b1;
      frames_ended++;
    end
    w.bits = bit_cnt;
    decoder_outputs_q.push_back(w);
  endfunction

  task automatic send_word(input logic cmd, input logic [PeriodW-1:0] per);
    int unsigned gap;
    gap = burst_mode ? 0 : idle_length();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    period_i   <= per;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predict_decode(cmd, per);
    words_sent++;
  endtask

  task automatic drain_decoder();
    in_valid_i <= 1'b0;
    while (decoder_outputs_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [PeriodW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    case (idx)
      CfgTolerance: tol_pct   = val[TolW-1:0];
      CfgStart:     nom_start = val;
      CfgEnd:       nom_end   = val;
      CfgOne:       nom_one   = val;
      CfgZero:      nom_zero  = val;
      default: ;
    endcase
  endtask

  // only called with nothing outstanding
  task automatic load_config(input logic [PeriodW-1:0] tol, input logic [PeriodW-1:0] st,
                             input logic [PeriodW-1:0] en, input logic [PeriodW-1:0] one,
                             input logic [PeriodW-1:0] zero);
    write_reg(CfgTolerance, tol);
    write_reg(CfgStart, st);
    write_reg(CfgEnd, en);
    write_reg(CfgOne, one);
    write_reg(CfgZero, zero);
    cfg_we_i <= 1'b0;
    settings_loaded++;
  endtask

  task automatic send_pulse(input pulse_e kind);
    logic [PeriodW-1:0] nominal;
    logic [PeriodW-1:0] lo;
    logic [PeriodW:0]   hi;
    int unsigned        top;
    logic [PeriodW-1:0] per;
    case (kind)
      PulseStart: nominal = nom_start;
      PulseOne:   nominal = nom_one;
      PulseZero:  nominal = nom_zero;
      default:    nominal = nom_end;
    endcase
    window_bounds(nominal, lo, hi);
    if (int'(hi) > int'(lo) + 1) begin
      top = (int'(hi) - 1 > 65535) ? 65535 : int'(hi) - 1;
      per = PeriodW'($urandom_range(int'(lo) + 1, top));
    end else begin
      // empty window, the nominal itself goes unmatched
      per = nominal;
    end
    send_word(1'b0, per);
  endtask

  task automatic send_noise();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0:       send_word(1'b1, PeriodW'($urandom_range(0, 16'hFFFF)));
      1:       send_word(1'b0, 16'h0000);
      2:       send_word(1'b0, 16'hFFFF);
      default: send_word(1'b0, PeriodW'($urandom_range(0, 16'hFFFF)));
    endcase
  endtask

  task automatic random_frame(input bit noise_only);
    int unsigned kind;
    int unsigned nbits;
    int unsigned i;
    logic [35:0] pattern;
    pattern    = 36'({$urandom, $urandom});
    kind       = noise_only ? 99 : $urandom_range(0, 99);
    burst_mode = ($urandom_range(0, 3) == 0);
    if (kind >= 88) begin
      repeat ($urandom_range(1, 8)) send_noise();
    end else begin
      nbits = 32;
      if (kind >= 60 && kind < 70) nbits = $urandom_range(0, 31);
      else if (kind >= 70 && kind < 78) nbits = $urandom_range(33, 36);
      send_pulse(PulseStart);
      for (i = 0; i < nbits; i++) begin
        if (kind >= 78 && $urandom_range(0, 9) == 0) send_noise();
        send_pulse(pattern[i] ? PulseOne : PulseZero);
      end
      send_pulse(PulseEnd);
      if ($urandom_range(0, 1) == 1) send_word(1'b1, PeriodW'($urandom_range(0, 16'hFFFF)));
    end
    burst_mode = 1'b0;
  endtask

  task automatic run_random_frames(input int unsigned budget, input bit noise_only);
    int unsigned stop_at;
    stop_at = words_sent + budget;
    while (words_sent < stop_at) random_frame(noise_only);
    drain_decoder();
  endtask

  task automatic test_reset_state();
    send_word(1'b1, 16'h0000);
    send_word(1'b0, 16'h0000);
    send_word(1'b0, 16'hFFFF);
    send_word(1'b1, 16'hFFFF);
  endtask

  // bounds themselves lie outside, one tick inside matches
  task automatic test_window_edges();
    logic [PeriodW-1:0] lo;
    logic [PeriodW:0]   hi;
    window_bounds(nom_start, lo, hi);
    send_word(1'b0, lo);
    send_word(1'b0, lo + 1'b1);
    window_bounds(nom_one, lo, hi);
    send_word(1'b0, hi[PeriodW-1:0] - 1'b1);
    send_word(1'b0, hi[PeriodW-1:0]);
    window_bounds(nom_zero, lo, hi);
    send_word(1'b0, lo + 1'b1);
    window_bounds(nom_end, lo, hi);
    send_word(1'b0, hi[PeriodW-1:0] - 1'b1);
    send_word(1'b1, 16'h0000);
    drain_decoder();
  endtask

  task automatic test_overlapping_windows();
    load_config(16'd10, 16'd3000, 16'd1000, 16'd3000, 16'd1000);
    send_word(1'b0, 16'd1000);
    send_word(1'b0, 16'd3000);
    drain_decoder();
    load_config(16'd10, 16'd9000, 16'd20000, 16'd1000, 16'd1000);
    send_word(1'b0, 16'd1000);
    drain_decoder();
  endtask

  task automatic test_tolerance_extremes();
    // widest tolerance with zero nominals, then no tolerance at all
    load_config(16'd63, 16'd0, 16'hFFFF, 16'd100, 16'd0);
    send_word(1'b0, 16'd0);
    send_word(1'b0, 16'd37);
    send_word(1'b0, 16'd38);
    send_word(1'b0, 16'hFFFF);
    drain_decoder();
    load_config(16'hFFC0, StartReset, EndReset, OneReset, ZeroReset);
    send_word(1'b0, OneReset);
    send_word(1'b0, StartReset);
    drain_decoder();
  endtask

  task automatic test_random_traffic();
    load_config(TolReset, StartReset, EndReset, OneReset, ZeroReset);
    run_random_frames(380, 1'b0);
    load_config(16'd50, 16'd15000, 16'd50000, 16'd5000, 16'd1500);
    run_random_frames(280, 1'b0);
    load_config(16'd63, 16'hFFFF, 16'd200, 16'd10, 16'd3);
    run_random_frames(230, 1'b0);
    load_config(16'd0, StartReset, EndReset, OneReset, ZeroReset);
    run_random_frames(60, 1'b1);
    // upper data bits of the tolerance write are dropped, one window empty
    load_config(16'hFFD4, 16'd9000, 16'd30000, 16'd0, 16'd700);
    run_random_frames(140, 1'b0);
    load_config(16'd12, StartReset, EndReset, OneReset, ZeroReset);
    run_random_frames(200, 1'b0);
  endtask

  // far side holds off while words keep coming, so the input backs up
  task automatic test_output_hold();
    int unsigned i;
    hold_req   = 400;
    burst_mode = 1'b1;
    send_pulse(PulseStart);
    for (i = 0; i < 22; i++) send_pulse($urandom_range(0, 1) ? PulseOne : PulseZero);
    send_pulse(PulseEnd);
    burst_mode = 1'b0;
    drain_decoder();
  endtask

  initial begin : out_stall_gen
    int unsigned run_left;
    int unsigned stall_left;
    run_left    = 0;
    stall_left  = 0;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req != 0) begin
        stall_left = hold_req;
        hold_req   = 0;
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else if (run_left != 0) begin
        out_stall_i <= 1'b0;
        run_left--;
      end else begin
        out_stall_i <= 1'b0;
        run_left   = run_length();
        stall_left = idle_length();
      end
    end
  end

  always @(posedge clk_i) begin : check_result
    decode_word_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (decoder_outputs_q.size() == 0) begin
        mismatches++;
        $display("%0t: word with none outstanding: key %0d done %0b bits %0d", $time,
                 key_code_o, frame_done_o, bits_seen_o);
      end else begin
        want = decoder_outputs_q.pop_front();
        if (key_code_o !== want.key) begin
          mismatches++;
          $display("%0t: key_code expected %0d, got %0d", $time, want.key, key_code_o);
        end
        if (frame_done_o !== want.done) begin
          mismatches++;
          $display("%0t: frame_done expected %0b, got %0b", $time, want.done, frame_done_o);
        end
        if (bits_seen_o !== want.bits) begin
          mismatches++;
          $display("%0t: bits_seen expected %0d, got %0d", $time, want.bits, bits_seen_o);
        end
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: run did not finish within %0d cycles", $time, CycleLimit);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = CfgTolerance;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    command_i       = 1'b0;
    period_i        = '0;
    hold_req        = 0;
    burst_mode      = 1'b0;
    mismatches      = 0;
    words_sent      = 0;
    frames_ended    = 0;
    keys_decoded    = 0;
    settings_loaded = 1;
    tol_pct         = TolReset;
    nom_start       = StartReset;
    nom_end         = EndReset;
    nom_one         = OneReset;
    nom_zero        = ZeroReset;
    frame_acc       = '0;
    bit_cnt         = '0;
    key_held        = NoKey;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_window_edges();
    test_overlapping_windows();
    test_tolerance_extremes();
    test_random_traffic();
    test_output_hold();

    drain_decoder();
    repeat (8) @(posedge clk_i);
    $display("%0d words decoded under %0d register settings", words_sent, settings_loaded);
    $display("%0d frames ended, %0d of them with a full 32-bit key", frames_ended, keys_decoded);
    if (mismatches == 0 && decoder_outputs_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
hw/rtl/nip_pkg.sv
hw/rtl/nip_window.sv
hw/rtl/nec_ir_pulse_decoder.sv
tb/sv/nec_ir_pulse_decoder_tb.sv
